// ===== design/pds_pkg.sv =====
// Shared types and codes for the process dispatch scheduler.
package pds_pkg;

	localparam int ID_W   = 16;
	localparam int TIME_W = 16;

	// input opcodes
	localparam logic OP_ADD      = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	// scheduling policies; the unused code acts as FIFO
	localparam logic [1:0] MODE_FIFO = 2'd0;
	localparam logic [1:0] MODE_RR   = 2'd1;
	localparam logic [1:0] MODE_SJF  = 2'd2;

	// register indexes on the config port
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_SLICE = 1'b1;

	typedef enum logic [1:0] {
		ST_ADDED = 2'd0,
		ST_DISP  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_APPEND = 2'd1,
		CELL_SORTED = 2'd2,
		CELL_POP    = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] tm;
	} entry_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t op;
		entry_t   new_e;    // entry of an add beat
		logic     requeue;  // round robin head goes back to the tail
		entry_t   rq_e;     // head with its remaining time
	} cell_ctl_t;

endpackage

// ===== design/process_dispatch_scheduler.sv =====
// Top level of the process dispatch scheduler: cell row, control and ports.
//
// Usage: each input beat is either an add (opcode 0, proc_id, burst_len) or
// a dispatch request (opcode 1). Every accepted beat yields exactly one
// result beat carrying status, out_id, ran_for, finished and all_done.
// Both channels use valid/stall; a beat moves on a clock edge with valid
// high and stall low.
// Policy: sched_mode selects FIFO, round robin or shortest job first.
// time_slice is the round robin quantum. Write both over the APB port only
// while no beat is in flight.
// Storage is a row of STORE_DEPTH cells with the head in cell 0. Every
// cell shifts, inserts or holds in the same cycle, so an add or a dispatch
// completes in the cycle it is accepted.
// The result beat is registered and shows in the cycle after the input beat is
// accepted. Throughput: one beat per cycle while out_stall is low, set by the
// row update and the insertion search that ripples from the tail to the head
// across the cells in sorted adds. When the result register is full and
// out_stall is high, in_stall rises and no further beat is taken; nothing is lost.
// Reset empties the queue (entry count zero), selects FIFO, quantum 1.
// Cell contents are not cleared; only cells below the count are read.
module process_dispatch_scheduler
	import pds_pkg::*;
#(
	parameter int STORE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	// config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	input  logic [ID_W-1:0]   proc_id,
	input  logic [TIME_W-1:0] burst_len,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   out_id,
	output logic [TIME_W-1:0] ran_for,
	output logic              finished,
	output logic              all_done
);

	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STORE_DEPTH);

	// config registers
	logic [1:0]        sched_mode_q;
	logic [TIME_W-1:0] time_slice_q;
	logic              cfg_wr;

	// queue control
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic              in_acc;
	logic              is_full;
	logic              is_empty;
	cell_ctl_t         ctl;

	// head arithmetic for round robin
	entry_t            head_e;
	logic [TIME_W-1:0] ran_amt;
	logic [TIME_W-1:0] rem_left;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [TIME_W-1:0] ran_for_q;
	logic              finished_q;
	logic              all_done_q;
	status_t           status_nxt;
	logic [ID_W-1:0]   out_id_nxt;
	logic [TIME_W-1:0] ran_for_nxt;
	logic              finished_nxt;

	// cell row wiring
	entry_t            cell_e   [STORE_DEPTH];
	logic              cell_suf [STORE_DEPTH];

	//----------------------------------------------------------------------
	// APB registers
	//----------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_mode_q <= MODE_FIFO;
			time_slice_q <= TIME_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MODE:  sched_mode_q <= pwdata[1:0];
				REG_SLICE: time_slice_q <= pwdata[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE:  prdata = {30'd0, sched_mode_q};
			REG_SLICE: prdata = {{(32 - TIME_W){1'b0}}, time_slice_q};
			default:   prdata = '0;
		endcase
	end

	//----------------------------------------------------------------------
	// Handshake: a new beat enters unless the result register is held
	//----------------------------------------------------------------------
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign is_full  = count_q == FULL_CNT;
	assign is_empty = count_q == '0;

	//----------------------------------------------------------------------
	// Head of the queue: run for min(remaining, quantum)
	//----------------------------------------------------------------------
	assign head_e   = cell_e[0];
	assign ran_amt  = (head_e.tm < time_slice_q) ? head_e.tm : time_slice_q;
	assign rem_left = head_e.tm - ran_amt;

	always_comb begin
		ctl.op       = CELL_HOLD;
		ctl.new_e.id = proc_id;
		ctl.new_e.tm = burst_len;
		ctl.requeue  = (sched_mode_q == MODE_RR) && (rem_left != '0);
		ctl.rq_e.id  = head_e.id;
		ctl.rq_e.tm  = rem_left;

		count_nxt    = count_q;
		status_nxt   = ST_ADDED;
		out_id_nxt   = '0;
		ran_for_nxt  = '0;
		finished_nxt = 1'b0;

		if (opcode == OP_ADD) begin
			if (is_full) begin
				status_nxt = ST_FULL;
			end else begin
				// sorted insertion only in SJF; every other code appends
				ctl.op    = (sched_mode_q == MODE_SJF) ? CELL_SORTED : CELL_APPEND;
				count_nxt = count_q + CNT_W'(1);
			end
		end else begin
			if (is_empty) begin
				status_nxt = ST_EMPTY;
			end else begin
				ctl.op     = CELL_POP;
				status_nxt = ST_DISP;
				out_id_nxt = head_e.id;
				if (sched_mode_q == MODE_RR) begin
					ran_for_nxt  = ran_amt;
					finished_nxt = !ctl.requeue;
				end
				// a requeued head keeps the count unchanged
				count_nxt = ctl.requeue ? count_q : count_q - CNT_W'(1);
			end
		end

		if (!in_acc) begin
			ctl.op = CELL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc) begin
			count_q <= count_nxt;
		end
	end

	//----------------------------------------------------------------------
	// Row of cells; cell 0 is the head
	//----------------------------------------------------------------------
	for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   suf_left;
		logic   suf_right;

		if (k == 0) begin : g_first
			assign left_e   = '0;
			assign suf_left = 1'b1;
		end else begin : g_mid_l
			assign left_e   = cell_e[k-1];
			assign suf_left = cell_suf[k-1];
		end

		if (k == STORE_DEPTH - 1) begin : g_last
			assign right_e   = '0;
			assign suf_right = 1'b0;
		end else begin : g_mid_r
			assign right_e   = cell_e[k+1];
			assign suf_right = cell_suf[k+1];
		end

		pds_cell #(
			.IDX   (k),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.left_e    (left_e),
			.right_e   (right_e),
			.suf_left  (suf_left),
			.suf_right (suf_right),
			.suf       (cell_suf[k]),
			.entry     (cell_e[k])
		);
	end

	//----------------------------------------------------------------------
	// Result register
	//----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q   <= status_nxt;
			out_id_q   <= out_id_nxt;
			ran_for_q  <= ran_for_nxt;
			finished_q <= finished_nxt;
			all_done_q <= count_nxt == '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_id    = out_id_q;
	assign ran_for   = ran_for_q;
	assign finished  = finished_q;
	assign all_done  = all_done_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond store depth");

	a_empty_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && opcode == OP_DISPATCH && is_empty |=>
		out_valid && status == ST_EMPTY && all_done && out_id == '0)
		else $error("dispatch from empty queue misreported");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && opcode == OP_ADD && is_full |=>
		status == ST_FULL && $stable(count_q))
		else $error("add to full queue changed state");

	a_finish_rr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> status == ST_DISP && sched_mode_q == MODE_RR)
		else $error("finished flag outside a round robin dispatch");
`endif

endmodule

// ===== design/pds_cell.sv =====
// One queue cell: holds one entry and shifts, inserts or holds each cycle.
module pds_cell
	import pds_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 9
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [CNT_W-1:0] count,
	input  entry_t           left_e,
	input  entry_t           right_e,
	input  logic             suf_left,
	input  logic             suf_right,
	output logic             suf,
	output entry_t           entry
);

	localparam logic [CNT_W-1:0] MY_POS    = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] MY_POS_P1 = CNT_W'(IDX + 1);

	entry_t entry_q;
	logic   occupied;
	logic   le;

	// suf: some held entry at this place or further right has time <= new burst
	assign occupied = count > MY_POS;
	assign le       = occupied && (entry_q.tm <= ctl.new_e.tm);
	assign suf      = le | suf_right;
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_APPEND: begin
				if (count == MY_POS) begin
					entry_q <= ctl.new_e;
				end
			end
			CELL_SORTED: begin
				if (!suf_left) begin
					entry_q <= left_e;
				end else if (!suf) begin
					entry_q <= ctl.new_e;
				end
			end
			CELL_POP: begin
				if (ctl.requeue && count == MY_POS_P1) begin
					entry_q <= ctl.rq_e;
				end else begin
					entry_q <= right_e;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/sv/process_dispatch_scheduler_checker.sv =====
// Checker for the process dispatch scheduler: predicts each result beat and compares.
`timescale 1ns / 1ps

module process_dispatch_scheduler_checker
	import pds_pkg::*;
#(
	parameter int STORE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              opcode,
	input  logic [ID_W-1:0]   proc_id,
	input  logic [TIME_W-1:0] burst_len,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [ID_W-1:0]   out_id,
	input  logic [TIME_W-1:0] ran_for,
	input  logic              finished,
	input  logic              all_done,
	output int                mismatches,
	output int                outstanding
);

	localparam logic [2:0] MODE_ADDR  = {REG_MODE, 2'b00};
	localparam logic [2:0] SLICE_ADDR = {REG_SLICE, 2'b00};

	typedef struct {
		status_t           st;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] ran;
		logic              fin;
		logic              done;
	} dispatch_result_t;

	entry_t            run_queue[$];   // head first, same order as the cell row
	dispatch_result_t  awaited[$];
	logic [1:0]        policy  = MODE_FIFO;
	logic [TIME_W-1:0] quantum = 16'd1;
	int                errs    = 0;
	int                open_n  = 0;

	assign mismatches  = errs;
	assign outstanding = open_n;

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		errs++;
	endtask

	function automatic dispatch_result_t schedule_step(input logic op,
			input logic [ID_W-1:0] id, input logic [TIME_W-1:0] burst);
		dispatch_result_t  r;
		entry_t            head;
		int                pos;
		logic [TIME_W-1:0] left;
		r = '{ST_ADDED, '0, '0, 1'b0, 1'b0};
		if (op == OP_ADD) begin
			if (run_queue.size() >= STORE_DEPTH) begin
				r.st = ST_FULL;
			end else if (policy == MODE_SJF) begin
				// stable: equal times keep arrival order
				pos = run_queue.size();
				while (pos > 0 && run_queue[pos-1].tm > burst) pos--;
				run_queue.insert(pos, '{id: id, tm: burst});
			end else begin
				run_queue.push_back('{id: id, tm: burst});
			end
		end else if (run_queue.size() == 0) begin
			r.st = ST_EMPTY;
		end else begin
			head = run_queue.pop_front();
			r.st = ST_DISP;
			r.id = head.id;
			if (policy == MODE_RR) begin
				r.ran = (head.tm < quantum) ? head.tm : quantum;
				left = head.tm - r.ran;
				if (left != 0) begin
					run_queue.push_back('{id: head.id, tm: left});
				end else begin
					r.fin = 1'b1;
				end
			end
		end
		r.done = (run_queue.size() == 0);
		return r;
	endfunction

	task automatic check_result();
		dispatch_result_t want;
		if (awaited.size() == 0) begin
			report_mismatch("result beat with no beat outstanding");
			return;
		end
		want = awaited.pop_front();
		if (status !== want.st)
			report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
		if (out_id !== want.id)
			report_mismatch($sformatf("out_id %0h, expected %0h", out_id, want.id));
		if (ran_for !== want.ran)
			report_mismatch($sformatf("ran_for %0d, expected %0d", ran_for, want.ran));
		if (finished !== want.fin)
			report_mismatch($sformatf("finished %0b, expected %0b", finished, want.fin));
		if (all_done !== want.done)
			report_mismatch($sformatf("all_done %0b, expected %0b", all_done, want.done));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_queue.delete();
			awaited.delete();
			policy  = MODE_FIFO;
			quantum = 16'd1;
			open_n  = 0;
		end else begin
			if (out_valid && !out_stall) check_result();
			if (psel && penable && pwrite && pready) begin
				if (paddr == MODE_ADDR) policy = pwdata[1:0];
				else if (paddr == SLICE_ADDR) quantum = pwdata[TIME_W-1:0];
			end
			if (in_valid && !in_stall)
				awaited.push_back(schedule_step(opcode, proc_id, burst_len));
			open_n = awaited.size();
		end
	end

endmodule

// ===== tb/sv/process_dispatch_scheduler_test.sv =====
// Top of the process dispatch scheduler testbench: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module process_dispatch_scheduler_test;
	import pds_pkg::*;

	localparam int         DEPTH       = 256;
	localparam int         STALL_LIMIT = 2000;   // cycles with no handshake of any kind
	localparam logic [1:0] MODE_SPARE  = 2'd3;   // unassigned policy code, runs as FIFO
	localparam logic [2:0] MODE_ADDR   = {REG_MODE, 2'b00};
	localparam logic [2:0] SLICE_ADDR  = {REG_SLICE, 2'b00};

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite, pready;
	logic [2:0]        paddr;
	logic [31:0]       pwdata, prdata;
	logic              in_valid, in_stall, opcode;
	logic [ID_W-1:0]   proc_id, out_id;
	logic [TIME_W-1:0] burst_len, ran_for;
	logic              out_valid, out_stall, finished, all_done;
	logic [1:0]        status;
	int                mismatches, outstanding;

	// idle rates in percent; both zero during the closing phase
	int gap_pct   = 0;
	int stall_pct = 0;
	int idle_cycles = 0;

	process_dispatch_scheduler #(.STORE_DEPTH(DEPTH)) dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .opcode, .proc_id, .burst_len,
		.out_valid, .out_stall, .status, .out_id, .ran_for, .finished, .all_done
	);

	process_dispatch_scheduler_checker #(.STORE_DEPTH(DEPTH)) u_checker (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_valid, .in_stall, .opcode, .proc_id, .burst_len,
		.out_valid, .out_stall, .status, .out_id, .ran_for, .finished, .all_done,
		.mismatches, .outstanding
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: any beat, in either direction or on the register port, rearms it.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(psel && penable && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL process_dispatch_scheduler");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Result side back-pressure: out_stall rises in random bursts while stall_pct is nonzero.
	initial begin
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Mostly short jobs so round robin finishes often; the extremes show up too.
	function automatic logic [TIME_W-1:0] pick_burst();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return TIME_W'($urandom);
			default: return TIME_W'($urandom_range(0, 12));
		endcase
	endfunction

	// Present one beat and hold it until taken. An optional gap goes in front;
	// valid stays high between back-to-back beats.
	task automatic send_beat(input logic op, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] burst);
		int gap;
		gap = 0;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 18);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		proc_id   <= id;
		burst_len <= burst;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic add_proc(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] burst);
		send_beat(OP_ADD, id, burst);
	endtask

	// fields of a dispatch beat are don't-care; fill them with noise
	task automatic dispatch_next();
		send_beat(OP_DISPATCH, ID_W'($urandom), TIME_W'($urandom));
	endtask

	// Drop valid and wait for every predicted result to come back.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Registers only change with the block idle; held entries stay put.
	task automatic configure(input logic [1:0] mode, input logic [TIME_W-1:0] slice);
		settle();
		write_reg(MODE_ADDR, {30'd0, mode});
		write_reg(SLICE_ADDR, {16'd0, slice});
	endtask

	task automatic run_phase(input int count, input int add_pct);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < add_pct) add_proc(ID_W'($urandom), pick_burst());
			else dispatch_next();
		end
	endtask

	initial begin
		logic [1:0]        mode;
		logic [TIME_W-1:0] slice;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		opcode    = OP_ADD;
		proc_id   = '0;
		burst_len = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: FIFO out of reset, empty dispatch on both ends
		dispatch_next();
		add_proc(16'h0000, 16'h0000);
		add_proc(16'hFFFF, 16'hFFFF);
		add_proc(16'h1234, 16'd5);
		dispatch_next();
		dispatch_next();
		dispatch_next();
		dispatch_next();

		// round robin, zero quantum: zero-burst job leaves at once, the other requeues
		configure(MODE_RR, 16'd0);
		add_proc(16'd7, 16'd0);
		add_proc(16'd8, 16'd3);
		dispatch_next();
		dispatch_next();

		// quantum 2: runs 2, then the last 1 and finishes
		configure(MODE_RR, 16'd2);
		dispatch_next();
		dispatch_next();

		// shortest job first with a tie: equal bursts keep arrival order
		configure(MODE_SJF, 16'hFFFF);
		add_proc(16'd1, 16'd5);
		add_proc(16'd2, 16'd3);
		add_proc(16'd3, 16'd5);
		add_proc(16'd4, 16'd1);
		dispatch_next();
		dispatch_next();
		dispatch_next();
		dispatch_next();

		// spare policy code, then switch to round robin with the entry still held
		configure(MODE_SPARE, 16'd1);
		add_proc(16'd9, 16'd2);
		configure(MODE_RR, 16'd1);
		dispatch_next();

		// --- fill to the brim in sorted mode so adds get dropped, then drain
		gap_pct   = 15;
		stall_pct = 15;
		configure(MODE_SJF, 16'd3);
		run_phase(270, 100);
		run_phase(300, 8);

		// fill to the brim again in round robin with a one-unit quantum, then mostly dispatch
		configure(MODE_RR, 16'd1);
		run_phase(260, 100);
		run_phase(150, 8);

		// --- random phases across policies, quanta and idle rates
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 6)
				0:       mode = MODE_FIFO;
				1, 3:    mode = MODE_RR;
				2, 5:    mode = MODE_SJF;
				default: mode = MODE_SPARE;
			endcase
			case (ph % 5)
				0:       slice = 16'd0;
				1:       slice = 16'd1;
				2:       slice = 16'hFFFF;
				3:       slice = TIME_W'($urandom_range(2, 6));
				default: slice = TIME_W'($urandom);
			endcase
			case (ph % 3)
				0:       begin gap_pct = 0;  stall_pct = 0;  end
				1:       begin gap_pct = 15; stall_pct = 20; end
				default: begin gap_pct = 35; stall_pct = 35; end
			endcase
			configure(mode, slice);
			run_phase(100, (ph % 4 == 0) ? 30 : (ph % 4 == 1) ? 50 : (ph % 4 == 2) ? 60 : 45);
		end

		// --- closing stretch at full rate, no idling on either side
		gap_pct   = 0;
		stall_pct = 0;
		configure(MODE_RR, TIME_W'($urandom_range(1, 4)));
		run_phase(150, 50);

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS process_dispatch_scheduler");
		end else begin
			$display("FAIL process_dispatch_scheduler");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/pds_pkg.sv
design/pds_cell.sv
design/process_dispatch_scheduler.sv
tb/sv/process_dispatch_scheduler_checker.sv
tb/sv/process_dispatch_scheduler_test.sv
